[rtl/lped_pkg.sv]
// ----------------------------------------------------------------------------
// lped_pkg
// Shared types and constants for the length-prefixed entity deframer.
// ----------------------------------------------------------------------------
`default_nettype none
package lped_pkg;

	localparam int unsigned HEADER_BYTES = 6;
	localparam int unsigned RECORD_BYTES = 16;
	localparam int unsigned RECORD_START = 8;
	localparam int unsigned JOIN_MIN_BODY = 8;

	localparam logic REG_ENTITY_STATE_TYPE  = 1'b0;
	localparam logic REG_JOIN_RESPONSE_TYPE = 1'b1;

	localparam logic [3:0] KIND_UPDATED    = 4'd0;
	localparam logic [3:0] KIND_ADDED      = 4'd1;
	localparam logic [3:0] KIND_NOT_STORED = 4'd2;
	localparam logic [3:0] KIND_ENTITY_END = 4'd3;
	localparam logic [3:0] KIND_JOIN       = 4'd4;
	localparam logic [3:0] KIND_JOIN_SHORT = 4'd5;
	localparam logic [3:0] KIND_IGNORED    = 4'd6;
	localparam logic [3:0] KIND_SHORT_ERR  = 4'd7;
	localparam logic [3:0] KIND_LONG_ERR   = 4'd8;
	localparam logic [3:0] KIND_READ       = 4'd9;

	typedef enum logic [1:0] {
		OP_RESULT,
		OP_READ,
		OP_STORE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  kind;
		logic [31:0] id;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [5:0]  slot;
		logic        fend;
	} cmd_t;

endpackage
`default_nettype wire

[rtl/lped_fifo.sv]
// ----------------------------------------------------------------------------
// lped_fifo
// Two-entry command queue between the byte parser and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none
module lped_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lped_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output lped_pkg::cmd_t     head
);
	import lped_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end
endmodule
`default_nettype wire

[rtl/lped_front.sv]
// ----------------------------------------------------------------------------
// lped_front
// Byte parser: tracks the frame header, assembles records and join ids,
// and issues one command per result-bearing transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module lped_front #(
	parameter int MAX_ENTITIES   = 64,
	parameter int RECV_BUF_BYTES = 4096
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic          action,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [5:0]    read_index,
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [15:0]   cfg_data,
	output logic               push,
	output lped_pkg::cmd_t     push_cmd
);
	import lped_pkg::*;

	localparam int PW = $clog2(RECV_BUF_BYTES + 1);

	logic [15:0]   ent_type_q;
	logic [15:0]   join_type_q;
	logic [PW-1:0] pos_q;
	logic [31:0]   len_q;
	logic [15:0]   type_q;
	logic [15:0]   rcount_q;
	logic [31:0]   rw_q [4];
	logic [31:0]   local_id_q;

	logic [PW-1:0] pos_n;
	logic [31:0]   len_n;
	logic [15:0]   type_n;
	logic [15:0]   rcount_n;
	logic [31:0]   rw_n [4];
	logic [31:0]   local_id_n;
	logic [PW-1:0] pos_inc;
	logic [PW-1:0] b;
	logic [PW-1:0] rel;
	logic [3:0]    wi;
	logic [PW-5:0] ri;
	logic          have;
	logic          last;
	logic          body_ok;

	always_comb begin
		pos_n      = pos_q;
		len_n      = len_q;
		type_n     = type_q;
		rcount_n   = rcount_q;
		rw_n       = rw_q;
		local_id_n = local_id_q;
		push       = 1'b0;
		push_cmd   = '0;
		pos_inc    = pos_q + PW'(1);
		b          = pos_q - PW'(HEADER_BYTES);
		rel        = b - PW'(RECORD_START);
		wi         = rel[3:0];
		ri         = rel[PW-1:4];
		have       = 1'b0;
		last       = (32'(pos_inc) >= len_q);
		body_ok    = 1'b1;
		if (action) begin
			push          = accept;
			push_cmd.op   = OP_READ;
			push_cmd.kind = KIND_READ;
			push_cmd.slot = read_index;
		end else if (pos_q < PW'(4)) begin
			len_n = {((pos_q == '0) ? 24'd0 : len_q[23:0]), rx_byte};
			pos_n = pos_inc;
		end else begin
			if (pos_q < PW'(HEADER_BYTES))
				type_n = {type_q[7:0], rx_byte};
			if (pos_q == PW'(4)) begin
				pos_n   = pos_inc;
				body_ok = 1'b0;
			end else if (pos_q == PW'(HEADER_BYTES - 1) && len_q < 32'(HEADER_BYTES)) begin
				pos_n         = '0;
				body_ok       = 1'b0;
				push          = accept;
				push_cmd.op   = OP_RESULT;
				push_cmd.kind = KIND_SHORT_ERR;
			end else if (pos_q == PW'(HEADER_BYTES - 1) &&
					len_q > 32'(RECV_BUF_BYTES)) begin
				pos_n         = '0;
				body_ok       = 1'b0;
				push          = accept;
				push_cmd.op   = OP_RESULT;
				push_cmd.kind = KIND_LONG_ERR;
			end else if (pos_q >= PW'(HEADER_BYTES)) begin
				if (b == PW'(0))
					rcount_n = {rx_byte, 8'd0};
				else if (b == PW'(1))
					rcount_n = {rcount_q[15:8], rx_byte};
				if (type_q == join_type_q && b >= PW'(4) && b < PW'(8))
					rw_n[1] = {rw_q[1][23:0], rx_byte};
				if (type_q == ent_type_q && b >= PW'(RECORD_START)) begin
					if (wi == 4'd0) begin
						rw_n[1] = '0;
						rw_n[2] = '0;
						rw_n[3] = '0;
					end
					if (wi < 4'd4)
						rw_n[0] = {((wi == 4'd0) ? 24'd0 : rw_q[0][23:0]), rx_byte};
					else
						rw_n[wi[3:2]][8*wi[1:0] +: 8] = rx_byte;
					have = (wi == 4'd15) && (32'(ri) < 32'(rcount_q)) &&
						(32'(ri) < 32'(MAX_ENTITIES));
				end
			end
			if (body_ok) begin
				pos_n         = last ? '0 : pos_inc;
				push_cmd.id   = rw_n[0];
				push_cmd.x    = rw_n[1];
				push_cmd.y    = rw_n[2];
				push_cmd.z    = rw_n[3];
				push_cmd.fend = last;
				push_cmd.op   = have ? OP_STORE : OP_RESULT;
				push          = accept && (have || last);
				if (last && !have) begin
					push_cmd = '0;
					push_cmd.op   = OP_RESULT;
					push_cmd.fend = 1'b1;
					if (type_n == ent_type_q && len_q >= 32'(HEADER_BYTES + 2))
						push_cmd.kind = KIND_ENTITY_END;
					else if (type_n == join_type_q) begin
						if (len_q >= 32'(HEADER_BYTES + JOIN_MIN_BODY)) begin
							push_cmd.kind = KIND_JOIN;
							push_cmd.id   = rw_n[1];
							local_id_n    = rw_n[1];
						end else
							push_cmd.kind = KIND_JOIN_SHORT;
					end else
						push_cmd.kind = KIND_IGNORED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_type_q  <= 16'd0;
			join_type_q <= 16'd1;
			pos_q       <= '0;
			len_q       <= '0;
			type_q      <= '0;
			rcount_q    <= '0;
			rw_q        <= '{default: '0};
			local_id_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ENTITY_STATE_TYPE:  ent_type_q  <= cfg_data;
					REG_JOIN_RESPONSE_TYPE: join_type_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				pos_q      <= pos_n;
				len_q      <= len_n;
				type_q     <= type_n;
				rcount_q   <= rcount_n;
				rw_q       <= rw_n;
				local_id_q <= local_id_n;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/lped_back.sv]
// ----------------------------------------------------------------------------
// lped_back
// Table engine: linear id search, update or append, entry reads, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none
module lped_back #(
	parameter int MAX_ENTITIES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          empty,
	input  wire lped_pkg::cmd_t head,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [3:0]         kind,
	output logic [31:0]        obj_id,
	output logic [31:0]        pos_x,
	output logic [31:0]        pos_y,
	output logic [31:0]        pos_z,
	output logic [5:0]         slot,
	output logic               frame_end,
	output logic [6:0]         table_count,
	output logic               entry_valid
);
	import lped_pkg::*;

	localparam int IW = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
	localparam int CW = $clog2(MAX_ENTITIES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_SRD,
		ST_SCMP,
		ST_APPEND,
		ST_EMIT
	} state_t;

	state_t        state_q;
	cmd_t          cmd_q;
	logic [IW-1:0] j_q;
	logic [CW-1:0] used_q;
	logic [3:0]    res_kind_q;
	logic [5:0]    res_slot_q;
	logic          out_valid_q;

	logic [31:0]   id_mem [MAX_ENTITIES];
	logic [95:0]   wd_mem [MAX_ENTITIES];
	logic [31:0]   id_rd_q;
	logic [95:0]   wd_rd_q;
	logic [IW-1:0] rd_addr;
	logic          we;
	logic [IW-1:0] wa;
	logic          out_free;
	logic          rd_ok;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign pop       = (state_q == ST_IDLE) && !empty && out_free;
	assign rd_addr   = (state_q == ST_IDLE) ? IW'(head.slot) :
		(state_q == ST_RD) ? IW'(cmd_q.slot) : j_q;
	assign rd_ok     = (32'(head.slot) < 32'(used_q)) && (32'(head.slot) < 32'(MAX_ENTITIES));
	assign we        = (state_q == ST_APPEND && used_q < CW'(MAX_ENTITIES)) ||
		(state_q == ST_SCMP && id_rd_q == cmd_q.id);
	assign wa        = (state_q == ST_APPEND) ? IW'(used_q) : j_q;

	always_ff @(posedge clk) begin
		id_rd_q <= id_mem[rd_addr];
		wd_rd_q <= wd_mem[rd_addr];
		if (we) begin
			id_mem[wa] <= cmd_q.id;
			wd_mem[wa] <= {cmd_q.z, cmd_q.y, cmd_q.x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			j_q         <= '0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cmd_q <= head;
						j_q   <= '0;
						case (head.op)
							OP_STORE: state_q <= (used_q == '0) ? ST_APPEND : ST_SRD;
							OP_READ: begin
								if (rd_ok)
									state_q <= ST_RD;
								else begin
									out_valid_q <= 1'b1;
									kind        <= KIND_READ;
									obj_id      <= '0;
									pos_x       <= '0;
									pos_y       <= '0;
									pos_z       <= '0;
									slot        <= head.slot;
									frame_end   <= 1'b0;
									table_count <= 7'(used_q);
									entry_valid <= 1'b0;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
								kind        <= head.kind;
								obj_id      <= head.id;
								pos_x       <= '0;
								pos_y       <= '0;
								pos_z       <= '0;
								slot        <= '0;
								frame_end   <= head.fend;
								table_count <= 7'(used_q);
								entry_valid <= 1'b0;
							end
						endcase
					end
				end
				ST_RD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind        <= KIND_READ;
						obj_id      <= id_rd_q;
						pos_x       <= wd_rd_q[31:0];
						pos_y       <= wd_rd_q[63:32];
						pos_z       <= wd_rd_q[95:64];
						slot        <= cmd_q.slot;
						frame_end   <= 1'b0;
						table_count <= 7'(used_q);
						entry_valid <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_SRD: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (id_rd_q == cmd_q.id) begin
						res_kind_q <= KIND_UPDATED;
						res_slot_q <= 6'(j_q);
						state_q    <= ST_EMIT;
					end else if ((CW'(j_q) + CW'(1)) < used_q) begin
						j_q     <= j_q + IW'(1);
						state_q <= ST_SRD;
					end else
						state_q <= ST_APPEND;
				end
				ST_APPEND: begin
					if (used_q < CW'(MAX_ENTITIES)) begin
						res_kind_q <= KIND_ADDED;
						res_slot_q <= 6'(used_q);
						used_q     <= used_q + CW'(1);
					end else begin
						res_kind_q <= KIND_NOT_STORED;
						res_slot_q <= '0;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind        <= res_kind_q;
						obj_id      <= cmd_q.id;
						pos_x       <= cmd_q.x;
						pos_y       <= cmd_q.y;
						pos_z       <= cmd_q.z;
						slot        <= res_slot_q;
						frame_end   <= cmd_q.fend;
						table_count <= 7'(used_q);
						entry_valid <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/length_prefixed_entity_deframer_core.sv]
// ----------------------------------------------------------------------------
// length_prefixed_entity_deframer_core
// Deframes length-prefixed frames and keeps the entity table.
// Plain bytes are taken back to back while the command queue has room; each
// result-bearing transaction queues one command. A record result waits on a
// linear search of the table, entry by entry, so the two-entry queue can
// fill and stall the input until the engine catches up.
// Reset clears control state and the register defaults; table contents are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module length_prefixed_entity_deframer_core #(
	parameter int MAX_ENTITIES   = 64,
	parameter int RECV_BUF_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [5:0]  read_index,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       kind,
	output logic [31:0]      obj_id,
	output logic [31:0]      pos_x,
	output logic [31:0]      pos_y,
	output logic [31:0]      pos_z,
	output logic [5:0]       slot,
	output logic             frame_end,
	output logic [6:0]       table_count,
	output logic             entry_valid
);
	import lped_pkg::*;

	logic accept;
	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic empty;
	cmd_t head;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	lped_front #(
		.MAX_ENTITIES(MAX_ENTITIES),
		.RECV_BUF_BYTES(RECV_BUF_BYTES)
	) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .action(action),
		.rx_byte(rx_byte), .read_index(read_index), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .push(push), .push_cmd(push_cmd)
	);

	lped_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(push_cmd), .full(full),
		.pop(pop), .empty(empty), .head(head)
	);

	lped_back #(
		.MAX_ENTITIES(MAX_ENTITIES)
	) u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .head(head), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.obj_id(obj_id), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.slot(slot), .frame_end(frame_end), .table_count(table_count),
		.entry_valid(entry_valid)
	);
endmodule
`default_nettype wire
